/* src/sle_pkg.sv */
// Shared constants, codes and controller/datapath handshake structs for the
// sequential list engine. No dependencies.
package sle_pkg;

	// List geometry
	localparam int MAX_ENTRIES = 16;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Port field widths
	localparam int OP_W   = 2;
	localparam int POS_W  = 5;
	localparam int ELEM_W = 32;
	localparam int STAT_W = 3;
	localparam int LEN_W  = 5;

	// Width for position/length comparisons without overflow
	localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_GET    = 2'd0,
		OP_LOCATE = 2'd1,
		OP_INSERT = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;    // capture the request item
		logic start;   // set up the walk for the operation
		logic rd;      // issue one RAM read and step the walk
		logic take;    // consume the read data returned this cycle
		logic finish;  // commit the list update and load the result
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic err;     // request fails its checks
		logic rd_more; // reads still to issue
		logic dv;      // RAM read data valid this cycle
		logic hit;     // locate compare matched this cycle
	} stat_t;

endpackage

/* src/sle_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* src/sle_dp.sv */
// Datapath of the sequential list engine: request registers, length counter,
// walk counters, element RAM and result registers. Depends on sle_pkg, sle_ram.
module sle_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sle_pkg::cmd_t                 cmd,
	output sle_pkg::stat_t                st,
	input  logic [sle_pkg::OP_W-1:0]      op,
	input  logic [sle_pkg::POS_W-1:0]     position,
	input  logic [sle_pkg::ELEM_W-1:0]    value,
	output logic [sle_pkg::STAT_W-1:0]    status,
	output logic [sle_pkg::ELEM_W-1:0]    element,
	output logic [sle_pkg::POS_W-1:0]     found_position,
	output logic [sle_pkg::LEN_W-1:0]     list_length
);

	sle_pkg::op_t                    op_q;
	logic [sle_pkg::POS_W-1:0]       pos_q;
	logic [sle_pkg::DATA_W-1:0]      val_q;
	logic [sle_pkg::CNT_W-1:0]       count_q;
	logic [sle_pkg::IDX_W-1:0]       idx_q;
	logic [sle_pkg::IDX_W-1:0]       daddr_q;
	logic [sle_pkg::CNT_W-1:0]       rem_q;
	logic                            dv_q;
	logic                            hit_q;
	logic [sle_pkg::CNT_W-1:0]       found_q;
	logic [sle_pkg::DATA_W-1:0]      elem_q;

	sle_pkg::status_t                err_code;
	sle_pkg::status_t                res_status;
	logic [sle_pkg::CMP_W-1:0]       cnt_x;
	logic [sle_pkg::CMP_W-1:0]       pos_x;
	logic [sle_pkg::IDX_W-1:0]       pidx;
	logic                            pos_bad;
	logic                            is_err;
	logic                            hit;

	logic                            wr_en;
	logic [sle_pkg::IDX_W-1:0]       wr_addr;
	logic [sle_pkg::DATA_W-1:0]      wr_data;
	logic [sle_pkg::DATA_W-1:0]      rd_data;

	assign cnt_x   = sle_pkg::CMP_W'(count_q);
	assign pos_x   = sle_pkg::CMP_W'(pos_q);
	assign pidx    = sle_pkg::IDX_W'(pos_x - sle_pkg::CMP_W'(1));
	assign pos_bad = (pos_q == '0) || (pos_x > cnt_x);

	// Request checks; count only changes at finish so this holds until then
	always_comb begin
		err_code = sle_pkg::ST_OK;
		unique case (op_q)
			sle_pkg::OP_GET: begin
				if (pos_bad) err_code = sle_pkg::ST_BAD_POS;
			end
			sle_pkg::OP_LOCATE: begin
				err_code = sle_pkg::ST_OK;
			end
			sle_pkg::OP_INSERT: begin
				if (count_q == sle_pkg::CNT_W'(sle_pkg::MAX_ENTRIES))
					err_code = sle_pkg::ST_FULL;
				else if ((pos_q == '0) || (pos_x > cnt_x + sle_pkg::CMP_W'(1)))
					err_code = sle_pkg::ST_BAD_POS;
			end
			sle_pkg::OP_DELETE: begin
				if (count_q == '0) err_code = sle_pkg::ST_EMPTY;
				else if (pos_bad) err_code = sle_pkg::ST_BAD_POS;
			end
			default: err_code = sle_pkg::ST_OK;
		endcase
	end

	assign is_err = (err_code != sle_pkg::ST_OK);
	assign hit    = dv_q && (op_q == sle_pkg::OP_LOCATE) && (rd_data == val_q);

	assign st.err     = is_err;
	assign st.rd_more = (rem_q != '0);
	assign st.dv      = dv_q;
	assign st.hit     = hit;

	// Final status of the item
	always_comb begin
		if (is_err)
			res_status = err_code;
		else if ((op_q == sle_pkg::OP_LOCATE) && !hit_q)
			res_status = sle_pkg::ST_NOT_FOUND;
		else
			res_status = sle_pkg::ST_OK;
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= sle_pkg::op_t'(op);
			pos_q <= position;
			val_q <= sle_pkg::DATA_W'(value);
		end
	end

	// Walk counters: read index, reads remaining, returned-data address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			dv_q    <= 1'b0;
			idx_q   <= '0;
			daddr_q <= '0;
		end else begin
			dv_q <= cmd.rd;
			if (cmd.start) begin
				unique case (op_q)
					sle_pkg::OP_GET: begin
						idx_q <= pidx;
						rem_q <= sle_pkg::CNT_W'(1);
					end
					sle_pkg::OP_LOCATE: begin
						idx_q <= '0;
						rem_q <= count_q;
					end
					sle_pkg::OP_INSERT: begin
						idx_q <= sle_pkg::IDX_W'(cnt_x - sle_pkg::CMP_W'(1));
						rem_q <= sle_pkg::CNT_W'(cnt_x - pos_x + sle_pkg::CMP_W'(1));
					end
					sle_pkg::OP_DELETE: begin
						idx_q <= pidx;
						rem_q <= sle_pkg::CNT_W'(cnt_x - pos_x + sle_pkg::CMP_W'(1));
					end
					default: rem_q <= '0;
				endcase
			end else if (cmd.rd) begin
				rem_q   <= rem_q - sle_pkg::CNT_W'(1);
				daddr_q <= idx_q;
				if (op_q == sle_pkg::OP_INSERT)
					idx_q <= idx_q - sle_pkg::IDX_W'(1);
				else
					idx_q <= idx_q + sle_pkg::IDX_W'(1);
			end
		end
	end

	// Returned data: capture element, record locate hit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hit_q <= 1'b0;
		end else if (cmd.take) begin
			if (hit) begin
				hit_q   <= 1'b1;
				found_q <= sle_pkg::CNT_W'(daddr_q) + sle_pkg::CNT_W'(1);
			end
			if (daddr_q == pidx) elem_q <= rd_data;
		end
	end

	// RAM write: shift during the walk, new value at finish
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = daddr_q;
		wr_data = rd_data;
		if (cmd.take && (op_q == sle_pkg::OP_INSERT)) begin
			wr_en   = 1'b1;
			wr_addr = daddr_q + sle_pkg::IDX_W'(1);
		end else if (cmd.take && (op_q == sle_pkg::OP_DELETE) && (daddr_q != pidx)) begin
			wr_en   = 1'b1;
			wr_addr = daddr_q - sle_pkg::IDX_W'(1);
		end else if (cmd.finish && !is_err && (op_q == sle_pkg::OP_INSERT)) begin
			wr_en   = 1'b1;
			wr_addr = pidx;
			wr_data = val_q;
		end
	end

	sle_ram #(
		.WIDTH (sle_pkg::DATA_W),
		.DEPTH (sle_pkg::MAX_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	// Length counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.finish && !is_err) begin
			if (op_q == sle_pkg::OP_INSERT)
				count_q <= count_q + sle_pkg::CNT_W'(1);
			else if (op_q == sle_pkg::OP_DELETE)
				count_q <= count_q - sle_pkg::CNT_W'(1);
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status <= res_status;
			if (!is_err && ((op_q == sle_pkg::OP_GET) || (op_q == sle_pkg::OP_DELETE)))
				element <= sle_pkg::ELEM_W'(elem_q);
			else
				element <= '0;
			if (!is_err && (op_q == sle_pkg::OP_LOCATE) && hit_q)
				found_position <= sle_pkg::POS_W'(found_q);
			else
				found_position <= '0;
			if (is_err)
				list_length <= sle_pkg::LEN_W'(count_q);
			else if (op_q == sle_pkg::OP_INSERT)
				list_length <= sle_pkg::LEN_W'(count_q + sle_pkg::CNT_W'(1));
			else if (op_q == sle_pkg::OP_DELETE)
				list_length <= sle_pkg::LEN_W'(count_q - sle_pkg::CNT_W'(1));
			else
				list_length <= sle_pkg::LEN_W'(count_q);
		end
	end

endmodule

/* src/sle_ctrl.sv */
// Controller of the sequential list engine: sequences check, walk and finish
// and owns both handshakes. Depends on sle_pkg.
module sle_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  sle_pkg::stat_t st,
	output sle_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_RUN,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Result register can be reloaded when empty or being taken now
	assign out_free = !out_valid_q || !rsp_stall;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	// Commands
	always_comb begin
		cmd.load   = (state_q == S_IDLE) && req_valid;
		cmd.start  = (state_q == S_CHECK) && !st.err;
		cmd.rd     = (state_q == S_RUN) && st.rd_more && !st.hit;
		cmd.take   = (state_q == S_RUN) && st.dv;
		cmd.finish = (state_q == S_FIN) && out_free;
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (st.err) state_q <= S_FIN;
					else state_q <= S_RUN;
				end
				S_RUN: begin
					if (st.hit || !st.rd_more) state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/sequential_list_engine_top.sv */
// Top level of the sequential list engine: controller plus datapath.
// Depends on sle_pkg, sle_ctrl, sle_dp (and sle_ram below it).
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   request | req_valid/req_stall  | op, position, value
//   result  | rsp_valid/rsp_stall  | status, element, found_position, list_length
//
// One item at a time. Get reads one entry; locate, insert and delete walk the
// element RAM one entry per cycle through its single read port, at most
// MAX_ENTRIES entries per item. Failed checks go straight to finish.
// Reset clears the length and the handshake state; element RAM is not cleared.
// A held result stalls a finished item until it is taken; a new item is
// accepted while the previous result still waits.
module sequential_list_engine_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [sle_pkg::OP_W-1:0]   op,
	input  logic [sle_pkg::POS_W-1:0]  position,
	input  logic [sle_pkg::ELEM_W-1:0] value,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [sle_pkg::STAT_W-1:0] status,
	output logic [sle_pkg::ELEM_W-1:0] element,
	output logic [sle_pkg::POS_W-1:0]  found_position,
	output logic [sle_pkg::LEN_W-1:0]  list_length
);

	sle_pkg::cmd_t  cmd;
	sle_pkg::stat_t st;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.st        (st),
		.cmd       (cmd)
	);

	sle_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.op             (op),
		.position       (position),
		.value          (value),
		.status         (status),
		.element        (element),
		.found_position (found_position),
		.list_length    (list_length)
	);

endmodule

/* tb/sv/sequential_list_engine_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sequential_list_engine_top: a directed table,
// then random list traffic checked against a local list predictor.
// Depends on sle_pkg and the sequential_list_engine_top RTL.
module sequential_list_engine_top_tb;
	import sle_pkg::*;

	localparam int RAND_ITEMS    = 1320;
	localparam int QUIET_ITEMS   = 150;
	localparam int HOLD_AT       = 400;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = MAX_ENTRIES + 8;
	localparam int TIMEOUT_NS    = 5_000_000;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		status_t           status;
		logic [ELEM_W-1:0] element;
		logic [POS_W-1:0]  found_pos;
		logic [LEN_W-1:0]  length;
	} list_result_t;

	typedef struct {
		op_t               op;
		logic [POS_W-1:0]  pos;
		logic [ELEM_W-1:0] val;
		int                reps;
		bit                typed;
		list_result_t      want;
	} list_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [OP_W-1:0]     op;
	logic [POS_W-1:0]    position;
	logic [ELEM_W-1:0]   value;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [STAT_W-1:0]   status;
	logic [ELEM_W-1:0]   element;
	logic [POS_W-1:0]    found_position;
	logic [LEN_W-1:0]    list_length;

	// Predictor state: list contents and length
	logic [DATA_W-1:0]   model_elems [MAX_ENTRIES];
	int unsigned         model_len;

	list_result_t        expected_results [$];
	list_row_t           directed_rows [$];
	int                  mismatches;
	bit                  quiet;
	bit                  hold_rsp;

	always #5 clk = ~clk;

	sequential_list_engine_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.op             (op),
		.position       (position),
		.value          (value),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.element        (element),
		.found_position (found_position),
		.list_length    (list_length)
	);

	// List predictor: applies one operation to the local copy of the list
	function automatic list_result_t apply_list_op(op_t o, logic [POS_W-1:0] p,
			logic [ELEM_W-1:0] v);
		list_result_t r;
		int unsigned  pi;
		int           j;
		r.status    = ST_OK;
		r.element   = '0;
		r.found_pos = '0;
		pi = p;
		case (o)
			OP_GET: begin
				if (pi < 1 || pi > model_len)
					r.status = ST_BAD_POS;
				else
					r.element = model_elems[pi-1];
			end
			OP_LOCATE: begin
				r.status = ST_NOT_FOUND;
				for (j = 0; j < int'(model_len); j++) begin
					if (r.status == ST_NOT_FOUND && model_elems[j] == v) begin
						r.status    = ST_OK;
						r.found_pos = POS_W'(j + 1);
					end
				end
			end
			OP_INSERT: begin
				if (model_len >= MAX_ENTRIES) begin
					r.status = ST_FULL;
				end else if (pi < 1 || pi > model_len + 1) begin
					r.status = ST_BAD_POS;
				end else begin
					for (j = int'(model_len); j >= int'(pi); j--)
						model_elems[j] = model_elems[j-1];
					model_elems[pi-1] = v;
					model_len++;
				end
			end
			default: begin
				if (model_len == 0) begin
					r.status = ST_EMPTY;
				end else if (pi < 1 || pi > model_len) begin
					r.status = ST_BAD_POS;
				end else begin
					r.element = model_elems[pi-1];
					for (j = int'(pi) - 1; j + 1 < int'(model_len); j++)
						model_elems[j] = model_elems[j+1];
					model_len--;
				end
			end
		endcase
		r.length = LEN_W'(model_len);
		return r;
	endfunction

	task automatic add_row(op_t o, logic [POS_W-1:0] p, logic [ELEM_W-1:0] v, int reps,
			bit typed, status_t st, logic [ELEM_W-1:0] el, logic [POS_W-1:0] fp,
			logic [LEN_W-1:0] len);
		list_row_t row;
		row.op   = o;
		row.pos  = p;
		row.val  = v;
		row.reps = reps;
		row.typed = typed;
		row.want.status    = st;
		row.want.element   = el;
		row.want.found_pos = fp;
		row.want.length    = len;
		directed_rows.push_back(row);
	endtask

	// Offer one item, after an optional idle burst; expectation is queued first
	task automatic drive_item(op_t o, logic [POS_W-1:0] p, logic [ELEM_W-1:0] v,
			list_result_t want);
		int gap;
		expected_results.push_back(want);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		op        <= o;
		position  <= p;
		value     <= v;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// Result side: random stall bursts, one long hold-off, none near the end
	initial begin : rsp_side
		int  n;
		bit  hold_done;
		rsp_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp && !hold_done) begin
				hold_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 16);
				rsp_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: status=%0d element=%h found=%0d len=%0d",
						status, element, found_position, list_length);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || element !== want.element ||
						found_position !== want.found_pos || list_length !== want.length) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("result mismatch: exp status=%0d element=%h found=%0d len=%0d, got status=%0d element=%h found=%0d len=%0d",
							want.status, want.element, want.found_pos, want.length,
							status, element, found_position, list_length);
				end
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		list_result_t      want;
		list_row_t         row;
		logic [ELEM_W-1:0] value_pool [8];
		op_t               o;
		logic [POS_W-1:0]  p;
		logic [ELEM_W-1:0] v;
		int unsigned       limit;
		int                roll;
		int                waited;
		bit                filling;

		arst_n     = 1'b0;
		req_valid  = 1'b0;
		op         = OP_GET;
		position   = '0;
		value      = '0;
		mismatches = 0;
		quiet      = 1'b0;
		hold_rsp   = 1'b0;
		filling    = 1'b1;
		model_len  = 0;
		foreach (model_elems[k]) model_elems[k] = '0;

		value_pool[0] = '0;
		value_pool[1] = '1;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h0000_0001;
		for (int k = 4; k < 8; k++) value_pool[k] = $urandom;

		// Directed table; typed rows carry their own expectation
		add_row(OP_GET,    5'd1,  '0,            1,  1, ST_BAD_POS,   '0, 5'd0, 5'd0);
		add_row(OP_LOCATE, 5'd0,  '0,            1,  1, ST_NOT_FOUND, '0, 5'd0, 5'd0);
		add_row(OP_DELETE, 5'd1,  '0,            1,  1, ST_EMPTY,     '0, 5'd0, 5'd0);
		add_row(OP_INSERT, 5'd0,  32'h1111_1111, 1,  1, ST_BAD_POS,   '0, 5'd0, 5'd0);
		add_row(OP_INSERT, 5'd2,  32'h2222_2222, 1,  1, ST_BAD_POS,   '0, 5'd0, 5'd0);
		add_row(OP_INSERT, 5'd1,  '1,            1,  1, ST_OK,        '0, 5'd0, 5'd1);
		add_row(OP_INSERT, 5'd1,  '0,            1,  1, ST_OK,        '0, 5'd0, 5'd2);
		add_row(OP_LOCATE, 5'd31, '1,            1,  1, ST_OK,        '0, 5'd2, 5'd2);
		add_row(OP_GET,    5'd0,  '0,            1,  1, ST_BAD_POS,   '0, 5'd0, 5'd2);
		add_row(OP_GET,    5'd31, '0,            1,  1, ST_BAD_POS,   '0, 5'd0, 5'd2);
		add_row(OP_DELETE, 5'd0,  '0,            1,  1, ST_BAD_POS,   '0, 5'd0, 5'd2);
		add_row(OP_DELETE, 5'd31, '0,            1,  1, ST_BAD_POS,   '0, 5'd0, 5'd2);
		// fill the middle with duplicates up to full
		add_row(OP_INSERT, 5'd2,  32'h5A5A_A5A5, 14, 0, ST_OK,        '0, 5'd0, 5'd0);
		add_row(OP_INSERT, 5'd1,  32'h3333_3333, 1,  1, ST_FULL,      '0, 5'd0, 5'd16);
		add_row(OP_GET,    5'd16, '0,            1,  1, ST_OK,        '1, 5'd0, 5'd16);
		add_row(OP_LOCATE, 5'd0,  32'h1234_5678, 1,  1, ST_NOT_FOUND, '0, 5'd0, 5'd16);
		add_row(OP_LOCATE, 5'd0,  32'h5A5A_A5A5, 1,  0, ST_OK,        '0, 5'd0, 5'd0);
		add_row(OP_DELETE, 5'd16, '0,            1,  1, ST_OK,        '1, 5'd0, 5'd15);
		add_row(OP_DELETE, 5'd1,  '0,            1,  1, ST_OK,        '0, 5'd0, 5'd14);
		add_row(OP_GET,    5'd1,  '0,            1,  0, ST_OK,        '0, 5'd0, 5'd0);
		add_row(OP_INSERT, 5'd15, 32'h8000_0001, 1,  0, ST_OK,        '0, 5'd0, 5'd0);
		add_row(OP_DELETE, 5'd7,  '0,            1,  0, ST_OK,        '0, 5'd0, 5'd0);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			for (int k = 0; k < row.reps; k++) begin
				want = apply_list_op(row.op, row.pos, row.val);
				drive_item(row.op, row.pos, row.val, row.typed ? row.want : want);
			end
		end

		// Random traffic: the list swings between empty and full
		for (int i = 0; i < RAND_ITEMS; i++) begin
			quiet = (i >= RAND_ITEMS - QUIET_ITEMS);
			if (i == HOLD_AT) hold_rsp = 1'b1;
			if (model_len == MAX_ENTRIES && $urandom_range(0, 2) == 0) filling = 1'b0;
			if (model_len == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
			if ($urandom_range(0, 39) == 0) filling = ~filling;

			roll = $urandom_range(0, 99);
			if (roll < 40)
				o = filling ? OP_INSERT : OP_DELETE;
			else if (roll < 50)
				o = filling ? OP_DELETE : OP_INSERT;
			else if (roll < 75)
				o = OP_GET;
			else
				o = OP_LOCATE;

			limit = (o == OP_INSERT) ? model_len + 1 : model_len;
			if ($urandom_range(0, 99) < 85 && limit > 0)
				p = POS_W'($urandom_range(1, limit));
			else
				p = POS_W'($urandom_range(0, 31));

			roll = $urandom_range(0, 99);
			if (o == OP_LOCATE && model_len > 0 && roll < 60)
				v = model_elems[$urandom_range(0, model_len - 1)];
			else if (roll < 80)
				v = value_pool[$urandom_range(0, 7)];
			else
				v = $urandom;

			want = apply_list_op(o, p, v);
			drive_item(o, p, v, want);
		end

		@(negedge clk);
		req_valid <= 1'b0;

		// Drain outstanding results, then let the block settle
		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_results.size() != 0) begin
			$display("SCOREBOARD MISMATCH");
		end else begin
			repeat (SETTLE_CYCLES) @(posedge clk);
			if (mismatches == 0 && expected_results.size() == 0)
				$display("SCOREBOARD CLEAN");
			else
				$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
